/* hdl/pbrq_pkg.sv */
// ----------------------------------------------------------------------------
// pbrq_pkg
// shared types and constants for the priority bitmap ready queue
// ----------------------------------------------------------------------------
package pbrq_pkg;

  localparam int NumTasks  = 64;
  localparam int NumLevels = 32;
  localparam int TaskW     = 6;
  localparam int LevelW    = 5;
  localparam int CmdW      = 2;
  localparam int FifoDepth = 2;

  localparam logic [CmdW-1:0] CmdInsert   = 2'd0;
  localparam logic [CmdW-1:0] CmdRemove   = 2'd1;
  localparam logic [CmdW-1:0] CmdHead     = 2'd2;
  localparam logic [CmdW-1:0] CmdContains = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [TaskW-1:0]  task_id;
    logic [LevelW-1:0] level;
  } cmd_t;

endpackage

/* hdl/pbrq_front.sv */
// ----------------------------------------------------------------------------
// pbrq_front
// command intake: captures commands into a short queue for the back end
// ----------------------------------------------------------------------------
module pbrq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pbrq_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pbrq_pkg::cmd_t cmd_o
);
  import pbrq_pkg::*;

  cmd_t        mem_q [FifoDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* hdl/pbrq_back.sv */
// ----------------------------------------------------------------------------
// pbrq_back
// execution engine: link memories, bitmap and per-command sequencer
// ----------------------------------------------------------------------------
module pbrq_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  pbrq_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  output logic [pbrq_pkg::TaskW-1:0]  head_task_o,
  output logic                        head_valid_o,
  output logic                        is_member_o,
  output logic                        op_error_o
);
  import pbrq_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRd1  = 2'd1;
  localparam logic [1:0] StRd2  = 2'd2;
  localparam logic [1:0] StWr   = 2'd3;

  logic [1:0]           st_q, st_d;
  cmd_t                 c_q;
  logic [NumLevels-1:0] bitmap_q;
  logic [NumTasks-1:0]  flag_q;
  logic [LevelW-1:0]    qlev_q [NumTasks];
  logic [LevelW-1:0]    qlev_rd_q;
  logic [TaskW-1:0]     lhead_q [NumLevels];
  logic [TaskW-1:0]     nxt_q [NumTasks];
  logic [TaskW-1:0]     prv_q [NumTasks];
  // scratch registers: head, tail / next, prev
  logic [TaskW-1:0]     h_q, a_q, b_q;
  logic                 lvl_ne;
  logic                 ok_ins, ok_rem;
  logic [LevelW-1:0]    enc;
  logic                 any;

  assign lvl_ne = bitmap_q[c_q.level];
  assign ok_ins = !flag_q[c_q.task_id];
  assign ok_rem = flag_q[c_q.task_id] && (qlev_rd_q == c_q.level);

  always_comb begin
    enc = '0;
    any = 1'b0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (bitmap_q[i]) begin
        enc = LevelW'(i);
        any = 1'b1;
      end
    end
  end

  assign pop_o = (st_q == StIdle) && !empty_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (!empty_i) st_d = StRd1;
      StRd1: begin
        if (c_q.cmd == CmdInsert && ok_ins && lvl_ne) st_d = StRd2;
        else if (c_q.cmd == CmdRemove && ok_rem) st_d = StRd2;
        else st_d = StIdle;
      end
      StRd2: st_d = StWr;
      StWr: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= StIdle;
      bitmap_q     <= '0;
      flag_q       <= '0;
      res_valid_o  <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_o <= 1'b0;
      case (st_q)
        StRd1: begin
          case (c_q.cmd)
            CmdInsert: begin
              res_valid_o <= 1'b1;
              if (ok_ins) begin
                flag_q[c_q.task_id] <= 1'b1;
                if (!lvl_ne) bitmap_q[c_q.level] <= 1'b1;
              end
            end
            CmdRemove: begin
              if (!ok_rem) res_valid_o <= 1'b1;
            end
            default: res_valid_o <= 1'b1;
          endcase
        end
        StRd2: ;
        StWr: begin
          if (c_q.cmd == CmdRemove) begin
            res_valid_o         <= 1'b1;
            flag_q[c_q.task_id] <= 1'b0;
            if (a_q == c_q.task_id) bitmap_q[c_q.level] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and link memories
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        if (!empty_i) begin
          c_q       <= cmd_i;
          qlev_rd_q <= qlev_q[cmd_i.task_id];
        end
      end
      StRd1: begin
        head_task_o  <= '0;
        head_valid_o <= 1'b0;
        is_member_o  <= 1'b0;
        op_error_o   <= 1'b0;
        h_q          <= lhead_q[c_q.level];
        a_q          <= nxt_q[c_q.task_id];
        b_q          <= prv_q[c_q.task_id];
        case (c_q.cmd)
          CmdInsert: begin
            op_error_o <= !ok_ins;
            if (ok_ins) begin
              qlev_q[c_q.task_id] <= c_q.level;
              if (!lvl_ne) begin
                nxt_q[c_q.task_id]   <= c_q.task_id;
                prv_q[c_q.task_id]   <= c_q.task_id;
                lhead_q[c_q.level]   <= c_q.task_id;
              end
            end
          end
          CmdRemove: op_error_o <= !ok_rem;
          CmdHead: begin
            head_valid_o <= any;
            head_task_o  <= any ? lhead_q[enc] : '0;
          end
          default: is_member_o <= ok_rem;
        endcase
      end
      StRd2: begin
        if (c_q.cmd == CmdInsert) begin
          a_q                <= prv_q[h_q];
          prv_q[h_q]         <= c_q.task_id;
          nxt_q[c_q.task_id] <= h_q;
        end else begin
          if (a_q != c_q.task_id) begin
            if (h_q == c_q.task_id) lhead_q[c_q.level] <= a_q;
            nxt_q[b_q] <= a_q;
          end
        end
      end
      StWr: begin
        if (c_q.cmd == CmdInsert) begin
          nxt_q[a_q]         <= c_q.task_id;
          prv_q[c_q.task_id] <= a_q;
        end else if (a_q != c_q.task_id) begin
          prv_q[a_q] <= b_q;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/priority_bitmap_ready_queue.sv */
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue
// per-level task fifos with a non-empty bitmap and priority-encoded head
// ----------------------------------------------------------------------------
// channel   direction  signals
// command   in         start, busy, cmd_i, task_id_i, level_i
// result    out        done_o, head_task_o, head_valid_o, is_member_o, op_error_o
//
// the back end pops and executes a query, a refused command or an insert into an empty level,
// and adds the link memory read and write steps for insert into a non-empty level or remove
// done_o is registered in the execute step, or in the link write step for an accepted remove
// the receiver cannot stall; done_o marks a result for exactly one cycle
// busy rises only while the two-entry command queue is full
// asynchronous active-low reset empties the queue and clears bitmap and flags
// ----------------------------------------------------------------------------
module priority_bitmap_ready_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pbrq_pkg::CmdW-1:0]   cmd_i,
  input  logic [pbrq_pkg::TaskW-1:0]  task_id_i,
  input  logic [pbrq_pkg::LevelW-1:0] level_i,
  output logic                        done_o,
  output logic [pbrq_pkg::TaskW-1:0]  head_task_o,
  output logic                        head_valid_o,
  output logic                        is_member_o,
  output logic                        op_error_o
);
  import pbrq_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic full, empty, pop;

  assign in_cmd = '{cmd: cmd_i, task_id: task_id_i, level: level_i};
  assign busy   = full;

  // command queue decouples intake from execution
  pbrq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !full),
    .cmd_i   (in_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (q_cmd)
  );

  pbrq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (q_cmd),
    .pop_o        (pop),
    .res_valid_o  (done_o),
    .head_task_o  (head_task_o),
    .head_valid_o (head_valid_o),
    .is_member_o  (is_member_o),
    .op_error_o   (op_error_o)
  );

endmodule
